// ===== hw/rtl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg - shared types and constants for the thread scheduler
// Field widths, stream packing positions, operation and status codes.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int OPCODE_W = 3;
  localparam int TID_W    = 3;
  localparam int WORK_W   = 4;
  localparam int STATUS_W = 2;
  localparam int TSTATE_W = 2;

  // input item packing, lowest bit first
  localparam int IN_OP_LSB   = 0;
  localparam int IN_TID_LSB  = IN_OP_LSB + OPCODE_W;
  localparam int IN_WC_LSB   = IN_TID_LSB + TID_W;
  localparam int IN_USED_W   = IN_WC_LSB + WORK_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // result item packing, lowest bit first
  localparam int OUT_ST_LSB    = 0;
  localparam int OUT_RTHR_LSB  = OUT_ST_LSB + STATUS_W;
  localparam int OUT_RST_LSB   = OUT_RTHR_LSB + TID_W;
  localparam int OUT_HELD_BIT  = OUT_RST_LSB + TSTATE_W;
  localparam int OUT_OWN_LSB   = OUT_HELD_BIT + 1;
  localparam int OUT_WOKE_BIT  = OUT_OWN_LSB + TID_W;
  localparam int OUT_USED_W    = OUT_WOKE_BIT + 1;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [TSTATE_W-1:0] tstate_t;

  localparam opcode_t OP_CREATE   = 3'd0;
  localparam opcode_t OP_DISPATCH = 3'd1;
  localparam opcode_t OP_YIELD    = 3'd2;
  localparam opcode_t OP_LOCK     = 3'd3;
  localparam opcode_t OP_UNLOCK   = 3'd4;

  localparam status_t STAT_OK      = 2'd0;
  localparam status_t STAT_BLOCKED = 2'd1;
  localparam status_t STAT_NOREADY = 2'd2;
  localparam status_t STAT_ERROR   = 2'd3;

  localparam tstate_t TS_READY    = 2'd0;
  localparam tstate_t TS_RUNNING  = 2'd1;
  localparam tstate_t TS_BLOCKED  = 2'd2;
  localparam tstate_t TS_FINISHED = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic capture;   // latch item, issue table and queue head reads
    logic execute;   // apply operation, load result register
  } ctrl_cmd_t;

endpackage

// ===== hw/rtl/rrts_fifo.sv =====
// ----------------------------------------------------------------------------
// rrts_fifo - thread id queue
// Circular buffer with registered head read, push and pop.
// ----------------------------------------------------------------------------
module rrts_fifo #(
  parameter int DEPTH = 8,
  parameter int DW    = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] rd_data,
  output logic          empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] ent [DEPTH];
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [DW-1:0] rd_data_r;
  logic          full, do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;   // a push into a full queue is dropped
  assign do_pop  = pop && !empty;
  assign rd_data = rd_data_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt = (tail_r == PW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (do_pop) begin
      head_nxt = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent[tail_r] <= push_data;
    end
    if (rd_en) begin
      rd_data_r <= ent[head_r];
    end
  end

endmodule

// ===== hw/rtl/rrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrts_ctrl - scheduler sequencer
// Two-step item sequence and result register handshake.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output rrts_pkg::ctrl_cmd_t cmd
);

  import rrts_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.capture = (state_r == S_IDLE) && in_tvalid;
    cmd.execute = (state_r == S_EXEC) && (!out_valid_r || out_tready);

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.execute) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ===== hw/rtl/rrts_dp.sv =====
// ----------------------------------------------------------------------------
// rrts_dp - scheduler datapath
// Thread table, ready and wait queues, lock and running registers.
// ----------------------------------------------------------------------------
module rrts_dp #(
  parameter int MAX_THREADS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rrts_pkg::ctrl_cmd_t                  cmd,
  input  logic [rrts_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic [rrts_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  import rrts_pkg::*;

  localparam int IDW = $clog2(MAX_THREADS);
  localparam int CNW = $clog2(MAX_THREADS + 1);
  localparam int KW  = CNW + TID_W;

  // captured item
  opcode_t           op_r;
  logic [TID_W-1:0]  tid_r;
  logic [WORK_W-1:0] wc_r;

  // thread table
  tstate_t           thread_status [MAX_THREADS];
  logic [WORK_W-1:0] work_left     [MAX_THREADS];
  tstate_t           ts_rd_r;
  logic [WORK_W-1:0] wl_rd_r;

  logic [CNW-1:0] created_r, created_nxt;
  logic           lock_r, lock_nxt;
  logic [IDW-1:0] owner_r, owner_nxt;
  logic           run_valid_r, run_valid_nxt;
  logic [IDW-1:0] run_id_r, run_id_nxt;

  logic [OUT_TDATA_W-1:0] out_data_r;

  // queues
  logic           rq_push, rq_pop, rq_empty, wq_push, wq_pop, wq_empty;
  logic [IDW-1:0] rq_push_data, rq_head, wq_head;

  // table write port
  logic              ts_we, wl_we;
  logic [IDW-1:0]    tab_wa;
  tstate_t           ts_wd;
  logic [WORK_W-1:0] wl_wd;

  logic [TID_W-1:0]  in_tid;
  logic [IDW-1:0]    tid_idx;
  logic              known, caller_runs;
  logic [WORK_W-1:0] wl_dec;

  status_t          res_status;
  logic [TID_W-1:0] res_thread;
  tstate_t          res_state;
  logic             res_woke;

  assign in_tid      = in_tdata[IN_TID_LSB +: TID_W];
  assign tid_idx     = IDW'(tid_r);
  assign known       = KW'(tid_r) < KW'(created_r);
  assign caller_runs = run_valid_r && (run_id_r == tid_idx);
  assign wl_dec      = (wl_rd_r == '0) ? '0 : wl_rd_r - 1'b1;

  rrts_fifo #(.DEPTH(MAX_THREADS), .DW(IDW)) u_ready_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (cmd.capture),
    .push      (rq_push),
    .push_data (rq_push_data),
    .pop       (rq_pop),
    .rd_data   (rq_head),
    .empty     (rq_empty)
  );

  rrts_fifo #(.DEPTH(MAX_THREADS), .DW(IDW)) u_wait_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (cmd.capture),
    .push      (wq_push),
    .push_data (tid_idx),
    .pop       (wq_pop),
    .rd_data   (wq_head),
    .empty     (wq_empty)
  );

  always_comb begin
    created_nxt   = created_r;
    lock_nxt      = lock_r;
    owner_nxt     = owner_r;
    run_valid_nxt = run_valid_r;
    run_id_nxt    = run_id_r;
    rq_push       = 1'b0;
    rq_push_data  = tid_idx;
    rq_pop        = 1'b0;
    wq_push       = 1'b0;
    wq_pop        = 1'b0;
    ts_we         = 1'b0;
    wl_we         = 1'b0;
    tab_wa        = tid_idx;
    ts_wd         = TS_READY;
    wl_wd         = wc_r;
    res_status    = STAT_ERROR;
    res_thread    = tid_r;
    res_state     = TS_READY;
    res_woke      = 1'b0;

    case (op_r)
      OP_CREATE: begin
        res_thread = '0;
        if (created_r < CNW'(MAX_THREADS)) begin
          tab_wa       = IDW'(created_r);
          ts_we        = 1'b1;
          wl_we        = 1'b1;
          ts_wd        = TS_READY;
          wl_wd        = wc_r;
          rq_push      = 1'b1;
          rq_push_data = IDW'(created_r);
          created_nxt  = created_r + 1'b1;
          res_status   = STAT_OK;
          res_thread   = TID_W'(created_r);
          res_state    = TS_READY;
        end
      end
      OP_DISPATCH: begin
        if (run_valid_r) begin
          res_thread = TID_W'(run_id_r);
          res_state  = TS_RUNNING;
        end else if (rq_empty) begin
          res_status = STAT_NOREADY;
          res_thread = '0;
        end else begin
          rq_pop        = 1'b1;
          tab_wa        = rq_head;
          ts_we         = 1'b1;
          ts_wd         = TS_RUNNING;
          run_valid_nxt = 1'b1;
          run_id_nxt    = rq_head;
          res_status    = STAT_OK;
          res_thread    = TID_W'(rq_head);
          res_state     = TS_RUNNING;
        end
      end
      default: begin
        if (known) begin
          res_state = ts_rd_r;
          case (op_r)
            OP_YIELD: begin
              if (caller_runs) begin
                wl_we         = 1'b1;
                wl_wd         = wl_dec;
                ts_we         = 1'b1;
                ts_wd         = (wl_dec != '0) ? TS_READY : TS_FINISHED;
                rq_push       = (wl_dec != '0);
                run_valid_nxt = 1'b0;
                run_id_nxt    = '0;
                res_status    = STAT_OK;
                res_state     = ts_wd;
              end
            end
            OP_LOCK: begin
              if (caller_runs) begin
                if (!lock_r) begin
                  lock_nxt   = 1'b1;
                  owner_nxt  = tid_idx;
                  res_status = STAT_OK;
                end else begin
                  // held lock, even by the caller: caller waits
                  ts_we         = 1'b1;
                  ts_wd         = TS_BLOCKED;
                  wq_push       = 1'b1;
                  run_valid_nxt = 1'b0;
                  run_id_nxt    = '0;
                  res_status    = STAT_BLOCKED;
                  res_state     = TS_BLOCKED;
                end
              end
            end
            OP_UNLOCK: begin
              if (lock_r && owner_r == tid_idx) begin
                res_status = STAT_OK;
                if (!wq_empty) begin
                  // hand over to the oldest waiter
                  wq_pop       = 1'b1;
                  owner_nxt    = wq_head;
                  tab_wa       = wq_head;
                  ts_we        = 1'b1;
                  ts_wd        = TS_READY;
                  rq_push      = 1'b1;
                  rq_push_data = wq_head;
                  res_woke     = 1'b1;
                  res_thread   = TID_W'(wq_head);
                  res_state    = TS_READY;
                end else begin
                  lock_nxt  = 1'b0;
                  owner_nxt = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
    endcase

    if (!cmd.execute) begin
      rq_push = 1'b0;
      rq_pop  = 1'b0;
      wq_push = 1'b0;
      wq_pop  = 1'b0;
      ts_we   = 1'b0;
      wl_we   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      created_r   <= '0;
      lock_r      <= 1'b0;
      owner_r     <= '0;
      run_valid_r <= 1'b0;
      run_id_r    <= '0;
    end else if (cmd.execute) begin
      created_r   <= created_nxt;
      lock_r      <= lock_nxt;
      owner_r     <= owner_nxt;
      run_valid_r <= run_valid_nxt;
      run_id_r    <= run_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_tdata[IN_OP_LSB +: OPCODE_W];
      tid_r   <= in_tid;
      wc_r    <= in_tdata[IN_WC_LSB +: WORK_W];
      ts_rd_r <= thread_status[IDW'(in_tid)];
      wl_rd_r <= work_left[IDW'(in_tid)];
    end
    if (ts_we) begin
      thread_status[tab_wa] <= ts_wd;
    end
    if (wl_we) begin
      work_left[tab_wa] <= wl_wd;
    end
    if (cmd.execute) begin
      out_data_r <= {(OUT_TDATA_W - OUT_USED_W)'(0), res_woke,
                     TID_W'(owner_nxt), lock_nxt, res_state, res_thread, res_status};
    end
  end

  assign out_tdata = out_data_r;

endmodule

// ===== hw/rtl/round_robin_thread_scheduler_mutex.sv =====
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_mutex - thread scheduler with a shared lock
// Top level: sequencer, datapath and the stream ports.
// ----------------------------------------------------------------------------
// Each input item is one scheduler operation (create, dispatch, yield, lock,
// unlock) and gives exactly one result item. The accept step reads the
// caller's thread table entry and both queue heads into registers; the
// execute step then applies the operation and loads the result register.
// The thread table and the two queues are single-port memories with
// registered reads. A finished result waits in the output register while
// the next item is accepted; if the result is still not taken when that
// item is ready to complete, the block holds in its execute step. No
// clearing pass: only table and queue entries that were written are ever
// used.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_mutex #(
  parameter int MAX_THREADS = 8       // thread table and queue depth, 2..8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // opcode[2:0], thread_id[5:3], work_count[9:6], zero fill
  input  logic [rrts_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[1:0], result_thread[4:2], result_state[6:5], lock_held[7],
  // lock_owner[10:8], woke_waiter[11], zero fill
  output logic [rrts_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import rrts_pkg::*;

  ctrl_cmd_t cmd;

  // sequencer: accept, then execute once the result register is free
  rrts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // table, queues, lock and running thread
  rrts_dp #(.MAX_THREADS(MAX_THREADS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

// ===== hw/rtl/rrts_checker.sv =====
// ----------------------------------------------------------------------------
// rrts_checker - port-level checks for the thread scheduler
// Watches the stream ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module rrts_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [rrts_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rrts_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import rrts_pkg::*;

  logic             in_acc;
  status_t          o_status;
  logic             o_held, o_woke;
  logic [TID_W-1:0] o_owner;

  assign in_acc   = in_tvalid && in_tready;
  assign o_status = out_tdata[OUT_ST_LSB +: STATUS_W];
  assign o_held   = out_tdata[OUT_HELD_BIT];
  assign o_owner  = out_tdata[OUT_OWN_LSB +: TID_W];
  assign o_woke   = out_tdata[OUT_WOKE_BIT];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one item in flight: busy the cycle after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("item accepted while previous one executes");

  // a hand-over only comes with a good status and a held lock
  a_woke: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_woke |-> o_status == STAT_OK && o_held)
    else $error("waiter woken on a failed or lockless step");

  // free lock reports owner zero
  a_owner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !o_held |-> o_owner == '0)
    else $error("owner reported for a free lock");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind round_robin_thread_scheduler_mutex rrts_checker u_rrts_checker (.*);

// ===== tb/sched_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sched_result_checker - result predictor and comparator for the scheduler
// Watches both stream channels, predicts one result per accepted item from
// its own copy of the thread table, queues and lock, and compares every
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sched_result_checker #(
  parameter int MAX_THREADS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [rrts_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [rrts_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  items_seen,
  // scheduler state after every item seen so far, for stimulus shaping
  output logic                                hint_run_on,
  output logic [rrts_pkg::TID_W-1:0]          hint_run_id,
  output logic                                hint_lock_on,
  output logic [rrts_pkg::TID_W-1:0]          hint_lock_id,
  output int                                  hint_ready_cnt
);

  import rrts_pkg::*;

  typedef struct packed {
    logic             woke;
    logic [TID_W-1:0] owner;
    logic             held;
    tstate_t          rstate;
    logic [TID_W-1:0] rthr;
    status_t          status;
  } sched_result_t;

  tstate_t          thr_state [MAX_THREADS];
  logic [WORK_W-1:0] thr_work [MAX_THREADS];
  int               n_created;
  logic [TID_W-1:0] ready_ids [$];
  logic [TID_W-1:0] waiting_ids [$];
  logic             lock_on;
  logic [TID_W-1:0] lock_id;
  logic             run_on;
  logic [TID_W-1:0] run_id;

  sched_result_t    expected_results [$];
  int               fails = 0;
  int               n_accepted = 0;

  // applies one operation to the shadow state and returns its result
  function automatic sched_result_t predict_result(opcode_t op, logic [TID_W-1:0] tid,
                                                   logic [WORK_W-1:0] wc);
    sched_result_t    r;
    logic [TID_W-1:0] id;
    logic             known;
    r        = '0;
    r.status = STAT_ERROR;
    r.rthr   = tid;
    r.rstate = TS_READY;
    known    = (int'(tid) < n_created);
    if (op == OP_CREATE) begin
      r.rthr = '0;
      if (n_created < MAX_THREADS) begin
        id = TID_W'(n_created);
        n_created++;
        thr_state[id] = TS_READY;
        thr_work[id]  = wc;
        if (ready_ids.size() < MAX_THREADS) ready_ids = {ready_ids, id};
        r.status = STAT_OK;
        r.rthr   = id;
      end
    end else if (op == OP_DISPATCH) begin
      if (run_on) begin
        r.rthr   = run_id;
        r.rstate = TS_RUNNING;
      end else if (ready_ids.size() == 0) begin
        r.status = STAT_NOREADY;
        r.rthr   = '0;
      end else begin
        id = ready_ids.pop_front();
        thr_state[id] = TS_RUNNING;
        run_on   = 1'b1;
        run_id   = id;
        r.status = STAT_OK;
        r.rthr   = id;
        r.rstate = TS_RUNNING;
      end
    end else if (!known) begin
      // unknown caller: error, state untouched
    end else if (op == OP_YIELD) begin
      if (run_on && run_id == tid) begin
        if (thr_work[tid] != '0) thr_work[tid] = thr_work[tid] - 1'b1;
        if (thr_work[tid] != '0) begin
          thr_state[tid] = TS_READY;
          if (ready_ids.size() < MAX_THREADS) ready_ids = {ready_ids, tid};
        end else begin
          thr_state[tid] = TS_FINISHED;
        end
        run_on   = 1'b0;
        run_id   = '0;
        r.status = STAT_OK;
      end
      r.rstate = thr_state[tid];
    end else if (op == OP_LOCK) begin
      if (run_on && run_id == tid) begin
        if (!lock_on) begin
          lock_on  = 1'b1;
          lock_id  = tid;
          r.status = STAT_OK;
        end else begin
          // held lock, own or not, parks the caller
          thr_state[tid] = TS_BLOCKED;
          if (waiting_ids.size() < MAX_THREADS) waiting_ids = {waiting_ids, tid};
          run_on   = 1'b0;
          run_id   = '0;
          r.status = STAT_BLOCKED;
        end
      end
      r.rstate = thr_state[tid];
    end else if (op == OP_UNLOCK) begin
      r.rstate = thr_state[tid];
      if (lock_on && lock_id == tid) begin
        r.status = STAT_OK;
        if (waiting_ids.size() != 0) begin
          id = waiting_ids.pop_front();
          lock_id = id;
          thr_state[id] = TS_READY;
          if (ready_ids.size() < MAX_THREADS) ready_ids = {ready_ids, id};
          r.woke   = 1'b1;
          r.rthr   = id;
          r.rstate = TS_READY;
        end else begin
          lock_on = 1'b0;
          lock_id = '0;
        end
      end
    end else begin
      r.rstate = thr_state[tid];
    end
    r.held  = lock_on;
    r.owner = lock_on ? lock_id : '0;
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    sched_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        thr_state[i] = TS_READY;
        thr_work[i]  = '0;
      end
      n_created = 0;
      ready_ids.delete();
      waiting_ids.delete();
      lock_on = 1'b0;
      lock_id = '0;
      run_on  = 1'b0;
      run_id  = '0;
      expected_results.delete();
    end else begin
      // results first, so a stray result never meets this cycle's prediction
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with no prediction waiting: 0x%0h", out_tdata);
          fails++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", int'(exp_r.status),
                      int'(out_tdata[OUT_ST_LSB +: STATUS_W]));
          check_field("result_thread", int'(exp_r.rthr),
                      int'(out_tdata[OUT_RTHR_LSB +: TID_W]));
          check_field("result_state", int'(exp_r.rstate),
                      int'(out_tdata[OUT_RST_LSB +: TSTATE_W]));
          check_field("lock_held", int'(exp_r.held), int'(out_tdata[OUT_HELD_BIT]));
          check_field("lock_owner", int'(exp_r.owner),
                      int'(out_tdata[OUT_OWN_LSB +: TID_W]));
          check_field("woke_waiter", int'(exp_r.woke), int'(out_tdata[OUT_WOKE_BIT]));
        end
      end
      if (in_tvalid && in_tready) begin
        exp_r = predict_result(in_tdata[IN_OP_LSB +: OPCODE_W],
                               in_tdata[IN_TID_LSB +: TID_W],
                               in_tdata[IN_WC_LSB +: WORK_W]);
        expected_results = {expected_results, exp_r};
        n_accepted++;
      end
    end
    fail_count     <= fails;
    pending        <= expected_results.size();
    items_seen     <= n_accepted;
    hint_run_on    <= run_on;
    hint_run_id    <= run_id;
    hint_lock_on   <= lock_on;
    hint_lock_id   <= lock_id;
    hint_ready_cnt <= ready_ids.size();
  end

endmodule

// ===== tb/round_robin_thread_scheduler_mutex_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_mutex_test - stream test of the scheduler
// Drives scheduler operations into the block, stalls the result side at
// random and once for a long stretch, and leaves prediction and comparison
// to the checker beside the block. Gives the verdict at the end.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_mutex_test;
  import rrts_pkg::*;

  localparam int MAX_THREADS     = 8;
  localparam int RANDOM_ITEMS    = 925;   // plus the directed opening
  localparam int HOLD_OFF_CYCLES = 80;    // long receiver stall
  localparam int QUIET_LIMIT     = 1000;  // cycles with no item moving
  localparam int TAIL_CYCLES     = 10;    // idle margin after the last result

  // spare opcodes, the block must answer them with an error
  localparam opcode_t OP_SPARE_5 = 3'd5;
  localparam opcode_t OP_SPARE_6 = 3'd6;
  localparam opcode_t OP_SPARE_7 = 3'd7;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // opcode[2:0], thread_id[5:3], work_count[9:6], zero fill
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // status[1:0], result_thread[4:2], result_state[6:5], lock_held[7],
  // lock_owner[10:8], woke_waiter[11], zero fill
  logic [OUT_TDATA_W-1:0] out_tdata;

  int               fail_count;
  int               pending;
  int               items_seen;
  logic             hint_run_on;
  logic [TID_W-1:0] hint_run_id;
  logic             hint_lock_on;
  logic [TID_W-1:0] hint_lock_id;
  int               hint_ready_cnt;

  int sent = 0;  // items accepted on the input side

  round_robin_thread_scheduler_mutex #(
    .MAX_THREADS (MAX_THREADS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sched_result_checker #(
    .MAX_THREADS (MAX_THREADS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .items_seen     (items_seen),
    .hint_run_on    (hint_run_on),
    .hint_run_id    (hint_run_id),
    .hint_lock_on   (hint_lock_on),
    .hint_lock_id   (hint_lock_id),
    .hint_ready_cnt (hint_ready_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one item and returns at the edge that accepts it. Called at a
  // clock edge; the caller may offer the next item in that same step.
  task automatic send_item(opcode_t op, logic [TID_W-1:0] tid, logic [WORK_W-1:0] wc);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IN_OP_LSB  +: OPCODE_W] = op;
    d[IN_TID_LSB +: TID_W]    = tid;
    d[IN_WC_LSB  +: WORK_W]   = wc;
    // random sender gaps, none in the calm window
    if (!(sent >= 500 && sent < 650) && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // stimulus
  initial begin
    int unsigned      roll;
    opcode_t          op;
    logic [TID_W-1:0] tid;
    logic [WORK_W-1:0] wc;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed opening ---
    send_item(OP_DISPATCH, 3'd0, 4'd0);     // nothing ready yet
    send_item(OP_SPARE_7, 3'd7, 4'd15);     // spare opcode, unknown caller
    send_item(OP_CREATE, 3'd0, 4'd0);       // thread 0, no work at all
    send_item(OP_CREATE, 3'd5, 4'd15);      // thread 1, full work
    send_item(OP_CREATE, 3'd0, 4'd1);       // thread 2, one unit
    send_item(OP_SPARE_5, 3'd1, 4'd0);      // spare opcode, known caller
    send_item(OP_YIELD, 3'd1, 4'd0);        // yield while not running
    send_item(OP_UNLOCK, 3'd0, 4'd0);       // unlock of a free lock
    send_item(OP_DISPATCH, 3'd0, 4'd0);     // thread 0 runs
    send_item(OP_DISPATCH, 3'd0, 4'd0);     // dispatch while one runs
    send_item(OP_LOCK, 3'd0, 4'd0);         // lock taken
    send_item(OP_LOCK, 3'd0, 4'd0);         // owner relocks: parks itself
    send_item(OP_DISPATCH, 3'd0, 4'd0);     // thread 1 runs
    send_item(OP_LOCK, 3'd1, 4'd0);         // contended: thread 1 parks
    send_item(OP_UNLOCK, 3'd2, 4'd0);       // unlock by non-owner
    send_item(OP_UNLOCK, 3'd0, 4'd0);       // hands lock to oldest waiter
    send_item(OP_UNLOCK, 3'd0, 4'd0);       // and on to thread 1
    send_item(OP_UNLOCK, 3'd1, 4'd0);       // no waiters: lock freed
    send_item(OP_DISPATCH, 3'd0, 4'd0);     // thread 2
    send_item(OP_YIELD, 3'd2, 4'd0);        // last unit used: finished
    send_item(OP_DISPATCH, 3'd0, 4'd0);     // thread 0
    send_item(OP_YIELD, 3'd0, 4'd0);        // no work left: finished
    for (int i = 0; i < 5; i++)
      send_item(OP_CREATE, 3'd0, 4'd15);    // threads 3 to 7
    send_item(OP_CREATE, 3'd7, 4'd9);       // table full
    send_item(OP_SPARE_6, 3'd4, 4'd3);

    // --- random part ---
    // Mostly well-formed calls shaped by the checker's view of the state,
    // the rest raw noise. Shaped items wait until that view is up to date.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 70) begin
        while (items_seen != sent) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
        end
        roll = $urandom_range(0, 99);
        wc   = WORK_W'($urandom_range(0, 15));
        tid  = TID_W'($urandom_range(0, 7));
        if (!hint_run_on) begin
          if (hint_ready_cnt != 0 && roll < 75) begin
            op = OP_DISPATCH;
          end else if (hint_lock_on && roll < 90) begin
            op  = OP_UNLOCK;
            tid = hint_lock_id;
          end else begin
            op = opcode_t'($urandom_range(OP_CREATE, OP_UNLOCK));
          end
        end else begin
          if (roll < 10) begin
            op  = OP_YIELD;                 // spends work, so kept rare
            tid = hint_run_id;
          end else if (roll < 45) begin
            op  = OP_LOCK;
            tid = hint_run_id;
          end else if (roll < 75) begin
            op  = hint_lock_on ? OP_UNLOCK : OP_LOCK;
            tid = hint_lock_on ? hint_lock_id : hint_run_id;
          end else if (roll < 85) begin
            op = OP_DISPATCH;
          end else begin
            op = opcode_t'($urandom_range(OP_YIELD, OP_UNLOCK));  // likely wrong caller
          end
        end
      end else begin
        op  = opcode_t'($urandom_range(0, 7));
        tid = TID_W'($urandom_range(0, 7));
        wc  = WORK_W'($urandom_range(0, 15));
      end
      send_item(op, tid, wc);
    end

    // --- drain and verdict ---
    in_tvalid <= 1'b0;
    while (items_seen != sent || pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("round_robin_thread_scheduler_mutex verification clean");
    else
      $display("round_robin_thread_scheduler_mutex verification failed");
    $finish;
  end

  // result side: random stalls, a calm window and one long hold-off
  initial begin
    int taken;
    bit held_off;
    taken    = 0;
    held_off = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) taken++;
      if (!held_off && taken >= 150) begin
        // input keeps coming: block fills and drops in_tready
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= (taken >= 400 && taken < 550) || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // watchdog: ends the run if no item moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("round_robin_thread_scheduler_mutex verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_fifo.sv
hw/rtl/rrts_ctrl.sv
hw/rtl/rrts_dp.sv
hw/rtl/round_robin_thread_scheduler_mutex.sv
hw/rtl/rrts_checker.sv
tb/sched_result_checker.sv
tb/round_robin_thread_scheduler_mutex_test.sv
